// ===== rtl/core/stbpl_pkg.sv =====
`timescale 1ns / 1ps

package stbpl_pkg;

  localparam int unsigned MOTOR_STEPS    = 3200;
  localparam int unsigned ENCODER_COUNTS = 4000;
  localparam int unsigned MAX_BURST      = 8;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned ERR_W   = POS_W + 1;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned STEPS_W = 8;
  localparam int unsigned FREQ_W  = 12;
  localparam int unsigned CFG_W   = 12;

  // Errors at or above this magnitude always give a full burst.
  localparam int unsigned MAG_CLAMP = MAX_BURST * ENCODER_COUNTS;
  localparam int unsigned MAGC_W    = $clog2(MAG_CLAMP + 1);
  localparam int unsigned PROD_W    = MAGC_W + 16;

  localparam int unsigned TIER_3000_ABOVE = 800;
  localparam int unsigned TIER_1800_ABOVE = 200;
  localparam int unsigned TIER_900_ABOVE  = 50;
  localparam int unsigned TIER_450_ABOVE  = 15;

  localparam logic [FREQ_W-1:0] FREQ_3000 = 12'd3000;
  localparam logic [FREQ_W-1:0] FREQ_1800 = 12'd1800;
  localparam logic [FREQ_W-1:0] FREQ_900  = 12'd900;
  localparam logic [FREQ_W-1:0] FREQ_450  = 12'd450;
  localparam logic [FREQ_W-1:0] FREQ_400  = 12'd400;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_SET_TARGET  = 3'd1,
    CMD_SET_ZERO    = 3'd2,
    CMD_STOP        = 3'd3,
    CMD_CLEAR_FAULT = 3'd4,
    CMD_FLIP        = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    FAULT_NONE        = 2'd0,
    FAULT_NO_FEEDBACK = 2'd1,
    FAULT_DIRECTION   = 2'd2,
    FAULT_DRIVER      = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef enum logic [2:0] {
    CFG_TOLERANCE      = 3'd0,
    CFG_SETTLE         = 3'd1,
    CFG_NO_MOTION_LIM  = 3'd2,
    CFG_REVERSE_LIM    = 3'd3,
    CFG_MOVE_CONFIRM   = 3'd4,
    CFG_REVERSE_CONF   = 3'd5,
    CFG_POSITIVE_LEVEL = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  tolerance_counts;
    logic [3:0]  settle_ticks;
    logic [11:0] no_motion_step_limit;
    logic [11:0] reverse_step_limit;
    logic [7:0]  move_confirm_counts;
    logic [7:0]  reverse_confirm_counts;
    logic        positive_level_default;
  } cfg_t;

  typedef struct packed {
    logic              driver_error;
    logic              pulse_busy;
    logic [POS_W-1:0]  target_position;
    logic [POS_W-1:0]  position;
    cmd_e              command;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [1:0]         fault_code;
    logic               loop_active;
    logic               reached;
    logic               encoder_zero;
    logic               halt;
    logic [FREQ_W-1:0]  burst_frequency;
    logic [STEPS_W-1:0] burst_steps;
    logic               burst_direction;
    logic               burst_start;
  } result_t;

endpackage

// ===== rtl/core/stbpl_cfg_regs.sv =====
`timescale 1ns / 1ps

module stbpl_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_write_i,
  input  logic [2:0]                 cfg_index_i,
  input  logic [stbpl_pkg::CFG_W-1:0] cfg_data_i,
  output stbpl_pkg::cfg_t            cfg_o
);

  stbpl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write_i) begin
      unique case (stbpl_pkg::cfg_idx_e'(cfg_index_i))
        stbpl_pkg::CFG_TOLERANCE:      cfg_d.tolerance_counts       = cfg_data_i[7:0];
        stbpl_pkg::CFG_SETTLE:         cfg_d.settle_ticks           = cfg_data_i[3:0];
        stbpl_pkg::CFG_NO_MOTION_LIM:  cfg_d.no_motion_step_limit   = cfg_data_i[11:0];
        stbpl_pkg::CFG_REVERSE_LIM:    cfg_d.reverse_step_limit     = cfg_data_i[11:0];
        stbpl_pkg::CFG_MOVE_CONFIRM:   cfg_d.move_confirm_counts    = cfg_data_i[7:0];
        stbpl_pkg::CFG_REVERSE_CONF:   cfg_d.reverse_confirm_counts = cfg_data_i[7:0];
        stbpl_pkg::CFG_POSITIVE_LEVEL: cfg_d.positive_level_default = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance_counts       <= 8'd2;
      cfg_q.settle_ticks           <= 4'd3;
      cfg_q.no_motion_step_limit   <= 12'd64;
      cfg_q.reverse_step_limit     <= 12'd64;
      cfg_q.move_confirm_counts    <= 8'd2;
      cfg_q.reverse_confirm_counts <= 8'd3;
      cfg_q.positive_level_default <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/stbpl_in_stage.sv =====
`timescale 1ns / 1ps

module stbpl_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stbpl_pkg::item_t  in_item_i,
  output logic              item_valid_o,
  input  logic              item_take_i,
  output stbpl_pkg::item_t  item_o
);

  logic             valid_q, valid_d;
  stbpl_pkg::item_t item_q;
  logic             load;

  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/stbpl_loop.sv =====
`timescale 1ns / 1ps

module stbpl_loop (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  stbpl_pkg::item_t   item_i,
  input  stbpl_pkg::cfg_t    cfg_i,
  output stbpl_pkg::result_t result_o
);

  localparam int unsigned EW = stbpl_pkg::ERR_W;
  localparam int unsigned CW = stbpl_pkg::CNT_W;

  logic [stbpl_pkg::POS_W-1:0] target_q, target_d;
  logic [stbpl_pkg::POS_W-1:0] origin_q, origin_d;
  logic                        active_q, active_d;
  logic                        reached_q, reached_d;
  stbpl_pkg::fault_e           fault_q, fault_d;
  logic [3:0]                  settle_q, settle_d;
  logic                        pending_q, pending_d;
  stbpl_pkg::sign_e            sign_q, sign_d;
  logic [CW-1:0]               unc_q, unc_d;
  logic [CW-1:0]               rev_q, rev_d;
  logic                        inv_q, inv_d;

  logic signed [EW-1:0]            err;
  logic signed [EW-1:0]            mv;
  logic signed [EW-1:0]            mc_s;
  logic signed [EW-1:0]            rc_s;
  logic [EW-1:0]                   mag;
  logic [stbpl_pkg::MAGC_W-1:0]    mag_c;
  logic [stbpl_pkg::PROD_W-1:0]    prod;
  logic [stbpl_pkg::STEPS_W-1:0]   steps;
  logic [stbpl_pkg::FREQ_W-1:0]    freq;
  logic                            confirm;
  logic                            reverse;
  logic                            in_tol;
  logic                            lvl;
  stbpl_pkg::sign_e                err_sign;
  logic [CW:0]                     rev_sum;
  logic [CW:0]                     unc_sum;
  logic [CW-1:0]                   unc_base;

  assign err  = $signed({target_q[31], target_q}) - $signed({item_i.position[31], item_i.position});
  assign mv   = $signed({item_i.position[31], item_i.position}) - $signed({origin_q[31], origin_q});
  assign mc_s = $signed({{(EW-8){1'b0}}, cfg_i.move_confirm_counts});
  assign rc_s = $signed({{(EW-8){1'b0}}, cfg_i.reverse_confirm_counts});
  assign mag  = err[EW-1] ? EW'(-err) : EW'(err);

  assign mag_c = (mag > EW'(stbpl_pkg::MAG_CLAMP)) ?
                 stbpl_pkg::MAGC_W'(stbpl_pkg::MAG_CLAMP) : mag[stbpl_pkg::MAGC_W-1:0];
  assign prod  = stbpl_pkg::PROD_W'(mag_c) * stbpl_pkg::PROD_W'(stbpl_pkg::MOTOR_STEPS);

  always_comb begin
    steps = stbpl_pkg::STEPS_W'(1);
    for (int k = 1; k < stbpl_pkg::MAX_BURST; k++) begin
      if (prod > stbpl_pkg::PROD_W'(k) * stbpl_pkg::PROD_W'(stbpl_pkg::ENCODER_COUNTS)) begin
        steps = steps + stbpl_pkg::STEPS_W'(1);
      end
    end
  end

  always_comb begin
    if (mag > EW'(stbpl_pkg::TIER_3000_ABOVE)) begin
      freq = stbpl_pkg::FREQ_3000;
    end else if (mag > EW'(stbpl_pkg::TIER_1800_ABOVE)) begin
      freq = stbpl_pkg::FREQ_1800;
    end else if (mag > EW'(stbpl_pkg::TIER_900_ABOVE)) begin
      freq = stbpl_pkg::FREQ_900;
    end else if (mag > EW'(stbpl_pkg::TIER_450_ABOVE)) begin
      freq = stbpl_pkg::FREQ_450;
    end else begin
      freq = stbpl_pkg::FREQ_400;
    end
  end

  assign confirm  = (sign_q == stbpl_pkg::SIGN_POS && mv >= mc_s) ||
                    (sign_q == stbpl_pkg::SIGN_NEG && mv <= -mc_s);
  assign reverse  = (sign_q == stbpl_pkg::SIGN_POS && mv <= -rc_s) ||
                    (sign_q == stbpl_pkg::SIGN_NEG && mv >= rc_s);
  assign in_tol   = mag <= EW'(cfg_i.tolerance_counts);
  assign lvl      = cfg_i.positive_level_default ^ inv_q;
  assign err_sign = (!err[EW-1] && err != '0) ? stbpl_pkg::SIGN_POS : stbpl_pkg::SIGN_NEG;
  assign rev_sum  = {1'b0, rev_q} + {1'b0, unc_q};

  always_comb begin
    target_d  = target_q;
    origin_d  = origin_q;
    active_d  = active_q;
    reached_d = reached_q;
    fault_d   = fault_q;
    settle_d  = settle_q;
    pending_d = pending_q;
    sign_d    = sign_q;
    unc_d     = unc_q;
    rev_d     = rev_q;
    inv_d     = inv_q;
    unc_base  = '0;
    unc_sum   = '0;
    result_o  = '0;
    result_o.accepted = 1'b1;

    case (item_i.command)
      stbpl_pkg::CMD_TICK: begin
        if (!item_i.pulse_busy) begin
          if (pending_q) begin
            pending_d = 1'b0;
            if (confirm) begin
              unc_d = '0;
              rev_d = '0;
            end else if (reverse) begin
              rev_d  = rev_sum[CW] ? {CW{1'b1}} : rev_sum[CW-1:0];
              unc_d  = '0;
              sign_d = stbpl_pkg::SIGN_NONE;
              if (rev_d >= CW'(cfg_i.reverse_step_limit)) begin
                fault_d   = stbpl_pkg::FAULT_DIRECTION;
                active_d  = 1'b0;
                reached_d = 1'b0;
                unc_d     = '0;
                rev_d     = '0;
                result_o.halt = 1'b1;
              end
            end else if (unc_q >= CW'(cfg_i.no_motion_step_limit)) begin
              fault_d   = stbpl_pkg::FAULT_NO_FEEDBACK;
              active_d  = 1'b0;
              reached_d = 1'b0;
              unc_d     = '0;
              rev_d     = '0;
              result_o.halt = 1'b1;
            end
          end
          if (active_d && fault_d == stbpl_pkg::FAULT_NONE) begin
            if (in_tol) begin
              if (settle_q < cfg_i.settle_ticks) begin
                settle_d = settle_q + 4'd1;
              end
              if (settle_d >= cfg_i.settle_ticks) begin
                reached_d = 1'b1;
              end
            end else begin
              settle_d  = '0;
              reached_d = 1'b0;
              if (item_i.driver_error) begin
                fault_d   = stbpl_pkg::FAULT_DRIVER;
                active_d  = 1'b0;
                pending_d = 1'b0;
                unc_d     = '0;
                rev_d     = '0;
                result_o.halt = 1'b1;
              end else begin
                result_o.burst_start     = 1'b1;
                result_o.burst_direction = (err_sign == stbpl_pkg::SIGN_POS) ? lvl : !lvl;
                result_o.burst_steps     = steps;
                result_o.burst_frequency = freq;
                if (unc_d == '0 || sign_d != err_sign) begin
                  origin_d = item_i.position;
                  sign_d   = err_sign;
                  unc_base = '0;
                end else begin
                  unc_base = unc_d;
                end
                unc_sum   = {1'b0, unc_base} + (CW + 1)'(steps);
                unc_d     = unc_sum[CW] ? {CW{1'b1}} : unc_sum[CW-1:0];
                pending_d = 1'b1;
              end
            end
          end
        end
      end
      stbpl_pkg::CMD_SET_TARGET: begin
        if (fault_q != stbpl_pkg::FAULT_NONE) begin
          result_o.accepted = 1'b0;
        end else begin
          target_d  = item_i.target_position;
          active_d  = 1'b1;
          reached_d = 1'b0;
          settle_d  = '0;
        end
      end
      stbpl_pkg::CMD_SET_ZERO: begin
        result_o.halt         = 1'b1;
        result_o.encoder_zero = 1'b1;
        target_d  = '0;
        active_d  = 1'b0;
        reached_d = 1'b1;
        fault_d   = stbpl_pkg::FAULT_NONE;
        pending_d = 1'b0;
        unc_d     = '0;
        rev_d     = '0;
      end
      stbpl_pkg::CMD_STOP: begin
        result_o.halt = 1'b1;
        active_d  = 1'b0;
        reached_d = 1'b0;
        pending_d = 1'b0;
        unc_d     = '0;
        rev_d     = '0;
      end
      stbpl_pkg::CMD_CLEAR_FAULT: begin
        result_o.halt = 1'b1;
        target_d  = item_i.position;
        active_d  = 1'b0;
        reached_d = 1'b1;
        fault_d   = stbpl_pkg::FAULT_NONE;
        pending_d = 1'b0;
        unc_d     = '0;
        rev_d     = '0;
      end
      stbpl_pkg::CMD_FLIP: begin
        if (item_i.pulse_busy) begin
          result_o.accepted = 1'b0;
        end else begin
          inv_d = !inv_q;
          rev_d = '0;
        end
      end
      default: begin
        result_o.accepted = 1'b0;
      end
    endcase

    result_o.reached     = reached_d;
    result_o.loop_active = active_d;
    result_o.fault_code  = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      origin_q  <= '0;
      active_q  <= 1'b0;
      reached_q <= 1'b1;
      fault_q   <= stbpl_pkg::FAULT_NONE;
      settle_q  <= '0;
      pending_q <= 1'b0;
      sign_q    <= stbpl_pkg::SIGN_NONE;
      unc_q     <= '0;
      rev_q     <= '0;
      inv_q     <= 1'b0;
    end else if (fire_i) begin
      target_q  <= target_d;
      origin_q  <= origin_d;
      active_q  <= active_d;
      reached_q <= reached_d;
      fault_q   <= fault_d;
      settle_q  <= settle_d;
      pending_q <= pending_d;
      sign_q    <= sign_d;
      unc_q     <= unc_d;
      rev_q     <= rev_d;
      inv_q     <= inv_d;
    end
  end

  a_fault_stops_loop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q != stbpl_pkg::FAULT_NONE |-> !active_q)
    else $error("loop active while a fault is held");

  a_pending_has_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> sign_q != stbpl_pkg::SIGN_NONE)
    else $error("motion check pending without an expected direction");

  a_unconfirmed_has_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    unc_q != '0 |-> sign_q != stbpl_pkg::SIGN_NONE)
    else $error("unconfirmed steps held without an expected direction");

  a_burst_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.burst_start |->
      result_o.burst_steps != '0 &&
      result_o.burst_steps <= stbpl_pkg::STEPS_W'(stbpl_pkg::MAX_BURST) &&
      result_o.burst_frequency != '0)
    else $error("burst issued with an out-of-range step count or rate");

endmodule

// ===== rtl/core/stepper_burst_position_loop_core.sv =====
`timescale 1ns / 1ps

// Single-axis stepper position loop. One command is taken per clock cycle on the slave stream
// and its result leaves on the master stream through the input register, then the result
// register; the whole loop update sits in one combinational pass between the two, so a new
// transfer is accepted every cycle while the result register is free or being drained. The
// configuration channel is always ready and should be written only while the loop is idle.

module stepper_burst_position_loop_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // position[31:0], target_position, pulse_busy,
                                      // driver_error, zero padding
  input  logic [2:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // burst_start, burst_direction, burst_steps,
                                      // burst_frequency, halt, encoder_zero, reached,
                                      // loop_active, fault_code, accepted, zero padding
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  stbpl_pkg::item_t   in_item;
  stbpl_pkg::item_t   stage_item;
  stbpl_pkg::cfg_t    cfg;
  stbpl_pkg::result_t result;
  stbpl_pkg::result_t result_q;
  logic               stage_valid;
  logic               fire;
  logic               out_valid_q, out_valid_d;

  assign in_item.command         = stbpl_pkg::cmd_e'(s_axis_tuser);
  assign in_item.position        = s_axis_tdata[31:0];
  assign in_item.target_position = s_axis_tdata[63:32];
  assign in_item.pulse_busy      = s_axis_tdata[64];
  assign in_item.driver_error    = s_axis_tdata[65];

  assign cfg_ready_o = 1'b1;

  stbpl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  stbpl_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (stage_valid),
    .item_take_i  (fire),
    .item_o       (stage_item)
  );

  assign fire = stage_valid && (!out_valid_q || m_axis_tready);

  stbpl_loop u_loop (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, result_q};

endmodule
